### rtl/core/tsd_pkg.sv
`default_nettype none
package tsd_pkg;
    typedef enum logic [1:0] {PH_HEADER = 2'd0, PH_DATA = 2'd1, PH_HALTED = 2'd2} phase_t;
    typedef enum logic [1:0] {ST_SKIP = 2'd0, ST_DIGITS = 2'd1, ST_DONE = 2'd2} step_t;

    localparam logic [2:0] KIND_ENTRY    = 3'd0;
    localparam logic [2:0] KIND_DATA     = 3'd1;
    localparam logic [2:0] KIND_END      = 3'd2;
    localparam logic [2:0] KIND_CSUM_ERR = 3'd3;
    localparam logic [2:0] KIND_SHORT    = 3'd4;

    localparam logic [2:0] TYPE_REGULAR = 3'd0;
    localparam logic [2:0] TYPE_DIR     = 3'd5;

    localparam logic [8:0] OFF_SIZE_FIRST = 9'd124;
    localparam logic [8:0] OFF_SIZE_LAST  = 9'd135;
    localparam logic [8:0] OFF_CSUM_FIRST = 9'd148;
    localparam logic [8:0] OFF_CSUM_LAST  = 9'd155;
    localparam logic [8:0] OFF_TYPE       = 9'd156;
    localparam logic [8:0] OFF_LAST       = 9'd511;
    localparam logic [7:0] SPACE          = 8'h20;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  entry_type;
        logic [35:0] entry_size;
        logic [7:0]  file_byte;
        logic        last_of_entry;
    } result_t;
endpackage
`default_nettype wire

### rtl/core/tsd_if.sv
`default_nettype none
interface tsd_in_if (input wire logic clk);
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       input_ended;
    modport source (output valid, data_byte, input_ended, input ready);
    modport sink (input valid, data_byte, input_ended, output ready);
endinterface

interface tsd_out_if (input wire logic clk);
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  entry_type;
    logic [35:0] entry_size;
    logic [7:0]  file_byte;
    logic        last_of_entry;
    modport source (output valid, kind, entry_type, entry_size, file_byte, last_of_entry,
                    input ready);
    modport sink (input valid, kind, entry_type, entry_size, file_byte, last_of_entry,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/tsd_front.sv
`default_nettype none
module tsd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_ended,
    input  wire logic             fire,
    output tsd_pkg::result_t      res,
    output logic                  res_valid
);
    logic [8:0]      off_reg;
    tsd_pkg::phase_t phase_reg;
    logic [16:0]     sum_reg;
    logic [23:0]     csum_reg;
    tsd_pkg::step_t  cstep_reg;
    logic [35:0]     size_reg;
    tsd_pkg::step_t  sstep_reg;
    logic [7:0]      type_reg;
    logic            zero_reg;
    logic [35:0]     rem_reg;
    logic            emit_reg;

    logic        first, digit, in_csum, in_size;
    logic [16:0] sum_base, sum_new;
    logic [23:0] csum_base, csum_next;
    logic [35:0] size_base, size_next;
    tsd_pkg::step_t cstep_base, sstep_base, cstep_next, sstep_next;
    logic        zero_new;
    logic [7:0]  type_new;
    logic [2:0]  t;
    logic [35:0] sz;

    // header sums, octal field parsers and entry decode for the current byte
    always_comb
    begin
        first      = (off_reg == 9'd0);
        digit      = in_byte inside {[8'h30:8'h37]};
        in_csum    = off_reg inside {[tsd_pkg::OFF_CSUM_FIRST:tsd_pkg::OFF_CSUM_LAST]};
        in_size    = off_reg inside {[tsd_pkg::OFF_SIZE_FIRST:tsd_pkg::OFF_SIZE_LAST]};
        sum_base   = first ? 17'd0 : sum_reg;
        csum_base  = first ? 24'd0 : csum_reg;
        size_base  = first ? 36'd0 : size_reg;
        cstep_base = first ? tsd_pkg::ST_SKIP : cstep_reg;
        sstep_base = first ? tsd_pkg::ST_SKIP : sstep_reg;
        type_new   = (off_reg == tsd_pkg::OFF_TYPE) ? in_byte : (first ? 8'd0 : type_reg);
        zero_new   = (first | zero_reg) && (in_byte == 8'd0);
        sum_new    = sum_base + {9'd0, in_csum ? tsd_pkg::SPACE : in_byte};

        csum_next  = csum_base;
        cstep_next = cstep_base;
        if (in_csum)
        begin
            if (cstep_base == tsd_pkg::ST_SKIP)
            begin
                if (digit)
                begin
                    csum_next  = {21'd0, in_byte[2:0]};
                    cstep_next = tsd_pkg::ST_DIGITS;
                end
            end
            else if (cstep_base == tsd_pkg::ST_DIGITS)
            begin
                if (digit)
                    csum_next = {csum_base[20:0], in_byte[2:0]};
                else
                    cstep_next = tsd_pkg::ST_DONE;
            end
        end

        size_next  = size_base;
        sstep_next = sstep_base;
        if (in_size)
        begin
            if (sstep_base == tsd_pkg::ST_SKIP)
            begin
                if (digit)
                begin
                    size_next  = {33'd0, in_byte[2:0]};
                    sstep_next = tsd_pkg::ST_DIGITS;
                end
            end
            else if (sstep_base == tsd_pkg::ST_DIGITS)
            begin
                if (digit)
                    size_next = {size_base[32:0], in_byte[2:0]};
                else
                    sstep_next = tsd_pkg::ST_DONE;
            end
        end

        t = tsd_pkg::TYPE_REGULAR;
        if (type_new inside {[8'h31:8'h36]})
            t = type_new[2:0];
        sz = (t == tsd_pkg::TYPE_DIR) ? 36'd0 : size_base;
    end

    // classify the current transaction into at most one result
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        if (in_ended)
        begin
            res.kind  = tsd_pkg::KIND_SHORT;
            res_valid = (phase_reg != tsd_pkg::PH_HALTED);
        end
        else if (phase_reg == tsd_pkg::PH_HEADER && off_reg == tsd_pkg::OFF_LAST)
        begin
            res_valid = 1'b1;
            if (zero_new)
                res.kind = tsd_pkg::KIND_END;
            else if ({7'd0, sum_new} != csum_base)
                res.kind = tsd_pkg::KIND_CSUM_ERR;
            else
            begin
                res.kind       = tsd_pkg::KIND_ENTRY;
                res.entry_type = t;
                res.entry_size = sz;
            end
        end
        else if (phase_reg == tsd_pkg::PH_DATA && rem_reg != 36'd0 && emit_reg)
        begin
            res_valid         = 1'b1;
            res.kind          = tsd_pkg::KIND_DATA;
            res.file_byte     = in_byte;
            res.last_of_entry = (rem_reg == 36'd1);
        end
    end

    // advance parser state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            phase_reg <= tsd_pkg::PH_HEADER;
            sum_reg   <= '0;
            csum_reg  <= '0;
            cstep_reg <= tsd_pkg::ST_SKIP;
            size_reg  <= '0;
            sstep_reg <= tsd_pkg::ST_SKIP;
            type_reg  <= '0;
            zero_reg  <= 1'b1;
            rem_reg   <= '0;
            emit_reg  <= 1'b0;
        end
        else if (fire && in_valid)
        begin
            if (in_ended)
            begin
                off_reg   <= '0;
                phase_reg <= tsd_pkg::PH_HEADER;
                rem_reg   <= '0;
                emit_reg  <= 1'b0;
                zero_reg  <= 1'b1;
            end
            else if (phase_reg == tsd_pkg::PH_HEADER)
            begin
                off_reg   <= off_reg + 9'd1;
                sum_reg   <= sum_new;
                type_reg  <= type_new;
                zero_reg  <= zero_new;
                csum_reg  <= csum_next;
                cstep_reg <= cstep_next;
                size_reg  <= size_next;
                sstep_reg <= sstep_next;
                if (off_reg == tsd_pkg::OFF_LAST)
                begin
                    if (zero_new || {7'd0, sum_new} != csum_base)
                        phase_reg <= tsd_pkg::PH_HALTED;
                    else
                    begin
                        rem_reg   <= sz;
                        emit_reg  <= (t == tsd_pkg::TYPE_REGULAR);
                        phase_reg <= (sz != 36'd0) ? tsd_pkg::PH_DATA : tsd_pkg::PH_HEADER;
                    end
                end
            end
            else if (phase_reg == tsd_pkg::PH_DATA)
            begin
                off_reg <= off_reg + 9'd1;
                if (rem_reg != 36'd0)
                    rem_reg <= rem_reg - 36'd1;
                if (off_reg == tsd_pkg::OFF_LAST && rem_reg <= 36'd1)
                    phase_reg <= tsd_pkg::PH_HEADER;
            end
        end
    end

    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_valid && !in_ended && phase_reg == tsd_pkg::PH_HALTED) |-> !res_valid)
        else $error("result while halted");
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_valid && in_ended) |=> (phase_reg == tsd_pkg::PH_HEADER && off_reg == 9'd0))
        else $error("end of input did not re-arm");
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tsd_pkg::PH_DATA) |-> (rem_reg != 36'd0 || off_reg != 9'd0))
        else $error("data phase with nothing left at block start");
endmodule
`default_nettype wire

### rtl/core/tsd_queue.sv
`default_nettype none
module tsd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire tsd_pkg::result_t wr_data,
    output logic                  full,
    output logic                  rd_valid,
    input  wire logic             rd_en,
    output tsd_pkg::result_t      rd_data
);
    tsd_pkg::result_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rp_reg];

    // hold results in a two-entry ring
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    a_over: assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
        else $error("queue overflow");
    a_under: assert property (@(posedge clk) disable iff (!rst_n) !rd_valid |-> !rd_en)
        else $error("queue underflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("count slip");
endmodule
`default_nettype wire

### rtl/core/tar_stream_deframer.sv
`default_nettype none
// Ustar stream deframer. One archive byte is taken per cycle, back to back;
// each byte updates small per-header sums and octal parsers as it is accepted,
// and results (entry header, content byte, end, checksum error, short
// read) pass through a two-entry queue to the output, so input is accepted
// whenever that queue has room. Header results appear on the last byte of
// each 512-byte header block; padding and non-regular data give no result.
module tar_stream_deframer (
    input wire logic   clk,
    input wire logic   rst_n,
    tsd_in_if.sink     in_ch,
    tsd_out_if.source  out_ch
);
    tsd_pkg::result_t res, rd;
    logic res_valid, full, fire;

    assign in_ch.ready = !full;
    assign fire        = in_ch.valid && !full;

    tsd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_byte(in_ch.data_byte),
        .in_ended(in_ch.input_ended), .fire(fire), .res(res), .res_valid(res_valid)
    );

    tsd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(fire && res_valid), .wr_data(res), .full(full),
        .rd_valid(out_ch.valid), .rd_en(out_ch.valid && out_ch.ready), .rd_data(rd)
    );

    assign out_ch.kind          = rd.kind;
    assign out_ch.entry_type    = rd.entry_type;
    assign out_ch.entry_size    = rd.entry_size;
    assign out_ch.file_byte     = rd.file_byte;
    assign out_ch.last_of_entry = rd.last_of_entry;
endmodule
`default_nettype wire
